// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros use the clk and rst of the
// module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/bsds_pkg.sv
package bsds_pkg;

  // Default store sizes.
  localparam int MAX_CTRL_DEF   = 32;
  localparam int MAX_DEGREE_DEF = 7;
  localparam int MAX_KNOTS_DEF  = 40;

  // Configuration port.
  localparam int CFG_W = 6;
  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_CTRLS  = 2'd1;
  localparam logic [1:0] REG_KNOTS  = 2'd2;
  localparam logic [1:0] REG_SEGS   = 2'd3;

  localparam logic [2:0] DEGREE_RST = 3'd3;
  localparam logic [5:0] SEGS_RST   = 6'd16;

  // Opcodes of an input item.
  localparam logic [1:0] OP_LOAD_CTRL = 2'd0;
  localparam logic [1:0] OP_LOAD_KNOT = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;

  // Coordinate selectors for the blend sequencer.
  localparam logic [1:0] C_X = 2'd0;
  localparam logic [1:0] C_Y = 2'd1;
  localparam logic [1:0] C_Z = 2'd2;

  // One in Q16.16, the top of the blend weight range.
  localparam logic [16:0] Q_ONE = 17'h10000;

endpackage

// File: hdl/bspline_de_boor_sampler_top.sv
// B-spline curve sampler using De Boor evaluation in signed Q16.16.
// Input channel (in_valid/in_ready) carries load and evaluate items; the
// output channel (out_valid/out_ready) carries sampled points. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce this. An
// evaluate transfer emits max(seg_count,1)+1 points (two endpoints on
// fallback). A 39-step shared divider forms the parameter of each point, and
// each blend pair takes up to a 16-step divide for the weight plus three
// passes through the multiplier.
// in_ready is high only while the sequencer is idle; the block takes no new
// item during an evaluation. Results go through an output register, so a
// load may be accepted while the last point still waits for the receiver.
// When the receiver stalls, the sequencer holds at the point it wants to
// send. Reset clears the sequencer, the output valid flag and the registers
// to their defaults; the stores hold no defined value until written.
module bspline_de_boor_sampler_top import bsds_pkg::*; #(
  parameter int MAX_CTRL   = MAX_CTRL_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int MAX_KNOTS  = MAX_KNOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [5:0]         slot,
  input  logic signed [31:0] ctrl_x,
  input  logic signed [31:0] ctrl_y,
  input  logic signed [31:0] ctrl_z,
  input  logic signed [31:0] knot_value,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               last_point,
  output logic               fell_back
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_CTRL);
  localparam int KW = $clog2(MAX_KNOTS);
  localparam int LD = MAX_DEGREE + 1;
  localparam int DW = $clog2(LD);
  localparam int IW = $clog2(MAX_KNOTS + MAX_CTRL + 2 * MAX_DEGREE + 4) + 1;
  localparam logic [5:0] DIV_T_STEPS = 6'd39;
  localparam logic [5:0] DIV_A_STEPS = 6'd16;

  typedef enum logic [4:0] {
    S_IDLE, S_FB0, S_FB1, S_TMIN, S_TMAX, S_TDIFF, S_TMUL, S_TDIV0, S_DIV,
    S_TFIN, S_AFIN, S_SRD, S_SCMP, S_LRD, S_LWR, S_KA, S_KB, S_ALPHA,
    S_MUL, S_ACC, S_ORD, S_EMIT
  } state_t;

  // Configuration registers.
  logic [2:0] curve_degree;
  logic [5:0] ctrl_count;
  logic [5:0] knot_count;
  logic [5:0] seg_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_degree <= DEGREE_RST;
      ctrl_count   <= '0;
      knot_count   <= '0;
      seg_count    <= SEGS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGREE: curve_degree <= cfg_data[2:0];
        REG_CTRLS:  ctrl_count   <= cfg_data[5:0];
        REG_KNOTS:  knot_count   <= cfg_data[5:0];
        REG_SEGS:   seg_count    <= cfg_data[5:0];
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t state;
  logic signed [31:0] tmin, t, ka;
  logic signed [32:0] dspan;
  logic signed [50:0] mprod;
  logic [38:0] dvd, quo;
  logic [32:0] rem, dsr;
  logic [5:0] steps;
  logic div_t, t_neg;
  logic [16:0] alpha;
  logic [5:0] pt_idx;
  logic [IW-1:0] j, base;
  logic [DW-1:0] r;
  logic [1:0] c;
  logic signed [31:0] sx, sy, sz, ex, ey, ez;

  // Store read data.
  logic signed [31:0] cx_q, cy_q, cz_q, knot_q;
  logic signed [31:0] lx_l, lx_r, ly_l, ly_r, lz_l, lz_r;

  // Effective settings, saturated to the store sizes.
  logic [IW-1:0] p_w, n_w, kc_w, slot_w, tmax_idx, span_end, nm1, sp;
  logic [5:0] seg_w;
  logic fallback;

  always_comb begin
    p_w  = (IW'(curve_degree) > IW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : IW'(curve_degree);
    n_w  = (IW'(ctrl_count) > IW'(MAX_CTRL)) ? IW'(MAX_CTRL) : IW'(ctrl_count);
    kc_w = (IW'(knot_count) > IW'(MAX_KNOTS)) ? IW'(MAX_KNOTS) : IW'(knot_count);
    seg_w = (seg_count == '0) ? 6'd1 : seg_count;
    slot_w = IW'(slot);
    tmax_idx = kc_w - IW'(1) - p_w;
    span_end = kc_w - IW'(2) - p_w;
    nm1 = n_w - IW'(1);
    sp = (j > nm1) ? nm1 : j;
    fallback = (n_w <= p_w) || (kc_w < n_w + p_w + IW'(1));
  end

  logic accept, ld_ctrl, ld_knot, slot_free, emit_now;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ld_ctrl   = accept && (opcode == OP_LOAD_CTRL) && (slot_w < IW'(MAX_CTRL));
  assign ld_knot   = accept && (opcode == OP_LOAD_KNOT) && (slot_w < IW'(MAX_KNOTS));
  assign slot_free = !out_valid || out_ready;
  assign emit_now  = slot_free && (state == S_FB0 || state == S_FB1 || state == S_EMIT);

  // Store addresses.
  logic [IW-1:0] caddr_w, kaddr_w, jm1;
  logic [CW-1:0] caddr;
  logic [KW-1:0] kaddr;
  logic [DW-1:0] laddr_l, laddr_r;

  always_comb begin
    caddr_w = base + j;
    caddr   = caddr_w[CW-1:0];
    case (state)
      S_TMIN:  kaddr_w = p_w;
      S_TMAX:  kaddr_w = tmax_idx;
      S_SRD:   kaddr_w = j + IW'(1);
      S_KA:    kaddr_w = base + j;
      S_KB:    kaddr_w = base + j + p_w + IW'(1) - IW'(r);
      default: kaddr_w = '0;
    endcase
    kaddr   = kaddr_w[KW-1:0];
    jm1     = j - IW'(1);
    laddr_l = jm1[DW-1:0];
    laddr_r = j[DW-1:0];
  end

  // Control point and knot stores.
  logic signed [31:0] ctrl_x_mem [MAX_CTRL];
  logic signed [31:0] ctrl_y_mem [MAX_CTRL];
  logic signed [31:0] ctrl_z_mem [MAX_CTRL];
  logic signed [31:0] knot_mem [MAX_KNOTS];

  always_ff @(posedge clk) begin
    if (ld_ctrl) begin
      ctrl_x_mem[slot_w[CW-1:0]] <= ctrl_x;
      ctrl_y_mem[slot_w[CW-1:0]] <= ctrl_y;
      ctrl_z_mem[slot_w[CW-1:0]] <= ctrl_z;
    end
    cx_q <= ctrl_x_mem[caddr];
    cy_q <= ctrl_y_mem[caddr];
    cz_q <= ctrl_z_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (ld_knot) begin
      knot_mem[slot_w[KW-1:0]] <= knot_value;
    end
    knot_q <= knot_mem[kaddr];
  end

  // Blend operands for the current coordinate.
  logic signed [31:0] left_c, right_c, blend_new;
  logic signed [32:0] diff;
  logic [34:0] blend_sum;

  always_comb begin
    case (c)
      C_X:     begin left_c = lx_l; right_c = lx_r; end
      C_Y:     begin left_c = ly_l; right_c = ly_r; end
      default: begin left_c = lz_l; right_c = lz_r; end
    endcase
    diff      = {right_c[31], right_c} - {left_c[31], left_c};
    blend_sum = {{3{left_c[31]}}, left_c} + mprod[50:16];
    blend_new = blend_sum[31:0];
  end

  // Working points of the De Boor triangle.
  logic signed [31:0] lx_mem [LD];
  logic signed [31:0] ly_mem [LD];
  logic signed [31:0] lz_mem [LD];
  logic lwx_en, lwy_en, lwz_en;

  assign lwx_en = (state == S_LWR) || (state == S_ACC && c == C_X);
  assign lwy_en = (state == S_LWR) || (state == S_ACC && c == C_Y);
  assign lwz_en = (state == S_LWR) || (state == S_ACC && c == C_Z);

  always_ff @(posedge clk) begin
    if (lwx_en) lx_mem[laddr_r] <= (state == S_LWR) ? cx_q : blend_new;
    if (lwy_en) ly_mem[laddr_r] <= (state == S_LWR) ? cy_q : blend_new;
    if (lwz_en) lz_mem[laddr_r] <= (state == S_LWR) ? cz_q : blend_new;
    lx_l <= lx_mem[laddr_l];
    lx_r <= lx_mem[laddr_r];
    ly_l <= ly_mem[laddr_l];
    ly_r <= ly_mem[laddr_r];
    lz_l <= lz_mem[laddr_l];
    lz_r <= lz_mem[laddr_r];
  end

  // Shared multiplier: parameter offset or blend difference times weight.
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [50:0] mabs;

  always_comb begin
    if (state == S_TMUL) begin
      mul_a = dspan;
      mul_b = {12'b0, pt_idx};
    end else begin
      mul_a = diff;
      mul_b = {1'b0, alpha};
    end
    mul_p = mul_a * mul_b;
    mabs  = mprod[50] ? -mprod : mprod;
  end

  // Shared restoring divider, one quotient bit per step.
  logic [33:0] rem2, rem_sub;
  logic div_ge;
  logic [39:0] tq_s, t_sum;

  always_comb begin
    rem2    = {rem, dvd[38]};
    rem_sub = rem2 - {1'b0, dsr};
    div_ge  = (rem2 >= {1'b0, dsr});
    tq_s    = t_neg ? -{1'b0, quo} : {1'b0, quo};
    t_sum   = {{8{tmin[31]}}, tmin} + tq_s;
  end

  // Blend weight operands.
  logic signed [32:0] w, num;
  assign w   = {knot_q[31], knot_q} - {ka[31], ka};
  assign num = {t[31], t} - {ka[31], ka};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Output valid rises when a point enters the output register and falls
      // once the receiver takes it.
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && opcode == OP_EVAL) begin
            sx <= start_x; sy <= start_y; sz <= start_z;
            ex <= end_x;   ey <= end_y;   ez <= end_z;
            pt_idx <= '0;
            state <= fallback ? S_FB0 : S_TMIN;
          end
        end
        S_FB0: begin
          if (slot_free) begin
            out_x <= sx; out_y <= sy; out_z <= sz;
            last_point <= 1'b0;
            fell_back  <= 1'b1;
            state <= S_FB1;
          end
        end
        S_FB1: begin
          if (slot_free) begin
            out_x <= ex; out_y <= ey; out_z <= ez;
            last_point <= 1'b1;
            fell_back  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_TMIN: state <= S_TMAX;
        S_TMAX: begin
          tmin  <= knot_q;
          state <= S_TDIFF;
        end
        S_TDIFF: begin
          dspan <= {knot_q[31], knot_q} - {tmin[31], tmin};
          state <= S_TMUL;
        end
        S_TMUL: begin
          mprod <= mul_p;
          state <= S_TDIV0;
        end
        S_TDIV0: begin
          t_neg <= mprod[50];
          dvd   <= mabs[38:0];
          rem   <= '0;
          dsr   <= {27'b0, seg_w};
          quo   <= '0;
          steps <= DIV_T_STEPS;
          div_t <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          dvd <= {dvd[37:0], 1'b0};
          if (div_ge) begin
            rem <= rem_sub[32:0];
            quo <= {quo[37:0], 1'b1};
          end else begin
            rem <= rem2[32:0];
            quo <= {quo[37:0], 1'b0};
          end
          steps <= steps - 6'd1;
          if (steps == 6'd1) state <= div_t ? S_TFIN : S_AFIN;
        end
        S_TFIN: begin
          t     <= t_sum[31:0];
          j     <= p_w;
          state <= S_SRD;
        end
        S_AFIN: begin
          alpha <= {1'b0, quo[15:0]};
          c     <= C_X;
          state <= S_MUL;
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if ((t < knot_q) || (j == span_end)) begin
            base  <= sp - p_w;
            j     <= '0;
            state <= S_LRD;
          end else begin
            j     <= j + IW'(1);
            state <= S_SRD;
          end
        end
        S_LRD: state <= S_LWR;
        S_LWR: begin
          if (j == p_w) begin
            if (p_w == '0) begin
              state <= S_ORD;
            end else begin
              r     <= DW'(1);
              state <= S_KA;
            end
          end else begin
            j     <= j + IW'(1);
            state <= S_LRD;
          end
        end
        S_KA: state <= S_KB;
        S_KB: begin
          ka    <= knot_q;
          state <= S_ALPHA;
        end
        S_ALPHA: begin
          if (w[32] || w == '0 || num[32] || num == '0) begin
            alpha <= '0;
            c     <= C_X;
            state <= S_MUL;
          end else if (num >= w) begin
            alpha <= Q_ONE;
            c     <= C_X;
            state <= S_MUL;
          end else begin
            rem   <= num;
            dvd   <= '0;
            dsr   <= w;
            quo   <= '0;
            steps <= DIV_A_STEPS;
            div_t <= 1'b0;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          mprod <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          if (c == C_Z) begin
            if (j == IW'(r)) begin
              if (IW'(r) == p_w) begin
                state <= S_ORD;
              end else begin
                r     <= r + DW'(1);
                j     <= p_w;
                state <= S_KA;
              end
            end else begin
              j     <= j - IW'(1);
              state <= S_KA;
            end
          end else begin
            c     <= c + 2'd1;
            state <= S_MUL;
          end
        end
        S_ORD: state <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            out_x <= lx_r; out_y <= ly_r; out_z <= lz_r;
            last_point <= (pt_idx == seg_w);
            fell_back  <= 1'b0;
            if (pt_idx == seg_w) begin
              state <= S_IDLE;
            end else begin
              pt_idx <= pt_idx + 6'd1;
              state  <= S_TMUL;
            end
          end
        end
      endcase
    end
  end

  // A blended coordinate always lies between its two inputs.
  `ASSERT_IMP(a_blend_range, state == S_ACC,
    (blend_new >= left_c && blend_new <= right_c) ||
    (blend_new <= left_c && blend_new >= right_c))
  // The blend weight never exceeds one.
  `ASSERT_IMP(a_alpha_range, state == S_MUL, alpha <= Q_ONE)
  // A point that cannot be sent keeps the sequencer waiting on it.
  `ASSERT_NXT(a_emit_hold, state == S_EMIT && !slot_free, state == S_EMIT)

endmodule

// File: tb/bspline_de_boor_sampler_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels, keeps its own copy of the
// point and knot stores, works out the curve points for every evaluate
// transfer and compares each output transfer with the oldest expected point.
module bspline_de_boor_sampler_checker import bsds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [5:0]         slot,
  input  logic signed [31:0] ctrl_x,
  input  logic signed [31:0] ctrl_y,
  input  logic signed [31:0] ctrl_z,
  input  logic signed [31:0] knot_value,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               last_point,
  input  logic               fell_back,
  output int                 errors,
  output int                 pending,
  output int                 items_seen,
  output int                 points_seen,
  output int                 fallbacks_seen
);

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
    logic        fb;
  } curve_point_t;

  curve_point_t expected_points[$];

  logic signed [31:0] px_mem [MAX_CTRL_DEF];
  logic signed [31:0] py_mem [MAX_CTRL_DEF];
  logic signed [31:0] pz_mem [MAX_CTRL_DEF];
  logic signed [31:0] knot_mem [MAX_KNOTS_DEF];

  logic [2:0] degree_r;
  logic [5:0] ctrls_r;
  logic [5:0] knots_r;
  logic [5:0] segs_r;

  // One De Boor blend of a coordinate pair, weight floored to Q16.16.
  function automatic longint blend_pair(longint lo, longint hi, longint t,
                                        longint ka, longint kb);
    longint w, num, a;
    w   = kb - ka;
    num = t - ka;
    if (w <= 0 || num <= 0) a = 0;
    else if (num >= w) a = 65536;
    else a = (num <<< 16) / w;
    return lo + (((hi - lo) * a) >>> 16);
  endfunction

  task automatic push_point(longint x, longint y, longint z, logic last, logic fb);
    curve_point_t pt;
    pt.x    = x[31:0];
    pt.y    = y[31:0];
    pt.z    = z[31:0];
    pt.last = last;
    pt.fb   = fb;
    expected_points = {expected_points, pt};
  endtask

  // Expected points of one evaluate transfer.
  task automatic predict_curve();
    int p, n, kc, seg, span, base;
    longint tmin, tmax, t, ka, kb;
    longint lx[MAX_DEGREE_DEF+1], ly[MAX_DEGREE_DEF+1], lz[MAX_DEGREE_DEF+1];
    p   = degree_r;
    n   = (ctrls_r > MAX_CTRL_DEF) ? MAX_CTRL_DEF : ctrls_r;
    kc  = (knots_r > MAX_KNOTS_DEF) ? MAX_KNOTS_DEF : knots_r;
    seg = (segs_r == 0) ? 1 : segs_r;
    if (n <= p || kc < n + p + 1) begin
      push_point(start_x, start_y, start_z, 1'b0, 1'b1);
      push_point(end_x, end_y, end_z, 1'b1, 1'b1);
      fallbacks_seen++;
      return;
    end
    tmin = knot_mem[p];
    tmax = knot_mem[kc-1-p];
    for (int i = 0; i <= seg; i++) begin
      t = tmin + ((tmax - tmin) * i) / seg;
      // Knot span search, clamped to the last control point.
      span = p;
      for (int j = p; j < kc - 1 - p; j++) begin
        if (t < knot_mem[j+1]) begin
          span = j;
          break;
        end
        span = kc - 2 - p;
      end
      if (span > n - 1) span = n - 1;
      base = span - p;
      for (int j = 0; j <= p; j++) begin
        lx[j] = px_mem[base+j];
        ly[j] = py_mem[base+j];
        lz[j] = pz_mem[base+j];
      end
      for (int r = 1; r <= p; r++) begin
        for (int j = p; j >= r; j--) begin
          ka = knot_mem[base+j];
          kb = knot_mem[base+j+p+1-r];
          lx[j] = blend_pair(lx[j-1], lx[j], t, ka, kb);
          ly[j] = blend_pair(ly[j-1], ly[j], t, ka, kb);
          lz[j] = blend_pair(lz[j-1], lz[j], t, ka, kb);
        end
      end
      push_point(lx[p], ly[p], lz[p], i == seg, 1'b0);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    items_seen = 0;
    points_seen = 0;
    fallbacks_seen = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      degree_r <= DEGREE_RST;
      ctrls_r  <= '0;
      knots_r  <= '0;
      segs_r   <= SEGS_RST;
      expected_points.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_DEGREE: degree_r <= cfg_data[2:0];
          REG_CTRLS:  ctrls_r  <= cfg_data;
          REG_KNOTS:  knots_r  <= cfg_data;
          REG_SEGS:   segs_r   <= cfg_data;
          default: ;
        endcase
      end
      // Input transfers update the stores or produce expected points.
      if (in_valid && in_ready) begin
        items_seen++;
        case (opcode)
          OP_LOAD_CTRL: begin
            if (slot < MAX_CTRL_DEF) begin
              px_mem[slot] = ctrl_x;
              py_mem[slot] = ctrl_y;
              pz_mem[slot] = ctrl_z;
            end
          end
          OP_LOAD_KNOT: begin
            if (slot < MAX_KNOTS_DEF) knot_mem[slot] = knot_value;
          end
          OP_EVAL: predict_curve();
          default: ;
        endcase
      end
      // Output transfers against the oldest expectation.
      if (out_valid && out_ready) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point, expected none, actual %h %h %h",
                   $time, out_x, out_y, out_z);
          errors++;
        end else begin
          curve_point_t e;
          e = expected_points.pop_front();
          check_field("out_x", e.x, out_x);
          check_field("out_y", e.y, out_y);
          check_field("out_z", e.z, out_z);
          check_field("last_point", {31'd0, e.last}, {31'd0, last_point});
          check_field("fell_back", {31'd0, e.fb}, {31'd0, fell_back});
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

// File: tb/bspline_de_boor_sampler_top_tb.sv
`timescale 1ns / 1ps

module bspline_de_boor_sampler_top_tb;
  import bsds_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 50;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [31:0] cx, cy, cz, kv, sx, sy, sz, ex, ey, ez;
  } sampler_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [5:0] slot = '0;
  logic signed [31:0] ctrl_x = '0, ctrl_y = '0, ctrl_z = '0, knot_value = '0;
  logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic last_point, fell_back;

  int errors, pending, items_seen, points_seen, fallbacks_seen;
  int tx_pct = 0;
  int rx_pct = 0;
  int items_sent = 0;
  int cycles = 0;
  int hold_cnt = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;

  bspline_de_boor_sampler_top u_top (.*);

  bspline_de_boor_sampler_checker u_chk (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off while points are waiting.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_done <= 1'b1;
    end else if (hold_armed && !hold_done && out_valid) begin
      out_ready <= 1'b0;
      hold_cnt <= LONG_HOLD;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_pct);
    end
  end

  task automatic set_idling(int mode);
    tx_pct = (mode == 1) ? 82 : (mode == 3) ? 19 : 0;
    rx_pct = (mode == 2) ? 82 : (mode == 3) ? 19 : 0;
  endtask

  function automatic sampler_item_t random_item(logic [1:0] op, logic [5:0] where);
    sampler_item_t it;
    it.op = op;
    it.slot = where;
    it.cx = $urandom; it.cy = $urandom; it.cz = $urandom; it.kv = $urandom;
    it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
    it.ex = $urandom; it.ey = $urandom; it.ez = $urandom;
    return it;
  endfunction

  // Offer one item and wait for its transfer; valid stays high afterwards.
  task automatic send_item(sampler_item_t it);
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid <= 1'b1;
    opcode <= it.op; slot <= it.slot;
    ctrl_x <= it.cx; ctrl_y <= it.cy; ctrl_z <= it.cz; knot_value <= it.kv;
    start_x <= it.sx; start_y <= it.sy; start_z <= it.sz;
    end_x <= it.ex; end_y <= it.ey; end_z <= it.ez;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering and let every expected point drain.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int p, int n, int k, int s);
    int vals[4];
    vals = '{p, n, k, s};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i][CFG_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Configure, load a full set of control points and sorted knots, then
  // evaluate a few times with noise loads and unused opcodes mixed in.
  task automatic run_curve(int p, int nreg, int kreg, int s, int evals, bit wide);
    int n, k, r;
    longint v;
    sampler_item_t it;
    n = (nreg > MAX_CTRL_DEF) ? MAX_CTRL_DEF : nreg;
    k = (kreg > MAX_KNOTS_DEF) ? MAX_KNOTS_DEF : kreg;
    drain();
    write_regs(p, nreg, kreg, s);
    for (int i = 0; i < n; i++) send_item(random_item(OP_LOAD_CTRL, 6'(i)));
    v = wide ? -64'sd2147483648 : -longint'($urandom_range(0, 1 << 30));
    for (int i = 0; i < k; i++) begin
      if (wide && k > 1) begin
        v = -64'sd2147483648 + (longint'(i) * 64'sd4294967295) / (k - 1);
        if (i != 0 && i != k - 1) v -= $urandom_range(0, 65535);
      end else if (i != 0) begin
        r = $urandom_range(0, 3);
        if (r == 1) v += $urandom_range(1, 255);
        else if (r == 2) v += $urandom_range(1, 1 << 16);
        else if (r == 3) v += $urandom_range(1, 1 << 22);
      end
      it = random_item(OP_LOAD_KNOT, 6'(i));
      it.kv = v[31:0];
      send_item(it);
    end
    for (int e = 0; e < evals; e++) begin
      send_item(random_item(OP_EVAL, 6'($urandom_range(0, 63))));
      if ($urandom_range(2) == 0) begin
        r = $urandom_range(0, 2);
        send_item(random_item((r == 2) ? OP_UNUSED : r[1:0],
                              6'($urandom_range(0, 63))));
      end
    end
  endtask

  initial begin
    sampler_item_t it;
    int c, p, n, k, s;
    set_idling(0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fallback with extreme edge vertices at reset settings.
    it = random_item(OP_EVAL, 6'd0);
    {it.sx, it.sy, it.sz} = {3{32'h7fffffff}};
    {it.ex, it.ey, it.ez} = {3{32'h80000000}};
    send_item(it);
    it = random_item(OP_EVAL, 6'd63);
    {it.sx, it.sy, it.sz} = {32'h80000000, 32'h0, 32'hffffffff};
    {it.ex, it.ey, it.ez} = {32'h7fffffff, 32'hffffffff, 32'h0};
    send_item(it);
    send_item(random_item(OP_UNUSED, 6'd5));
    // Out-of-range slots are ignored.
    send_item(random_item(OP_LOAD_CTRL, 6'd32));
    send_item(random_item(OP_LOAD_CTRL, 6'd63));
    send_item(random_item(OP_LOAD_KNOT, 6'd40));
    send_item(random_item(OP_LOAD_KNOT, 6'd63));
    // Linear curve across the full value range, zero segment count.
    drain();
    write_regs(1, 2, 4, 0);
    it = random_item(OP_LOAD_CTRL, 6'd0);
    {it.cx, it.cy, it.cz} = {32'h7fffffff, 32'h80000000, 32'h0};
    send_item(it);
    it = random_item(OP_LOAD_CTRL, 6'd1);
    {it.cx, it.cy, it.cz} = {32'h80000000, 32'h7fffffff, 32'hffffffff};
    send_item(it);
    for (int i = 0; i < 4; i++) begin
      it = random_item(OP_LOAD_KNOT, 6'(i));
      it.kv = (i < 2) ? 32'h80000000 : 32'h7fffffff;
      send_item(it);
    end
    send_item(random_item(OP_EVAL, 6'd0));

    // Largest curve once, with saturating counts and the widest knots.
    run_curve(7, 63, 63, 63, 1, 1);

    // Random curves through all idling modes.
    c = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_idling((c < 3) ? 0 : ((c - 3) / 3) % 4);
      hold_armed = (c == 10);
      p = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
      n = $urandom_range(0, 10);
      k = n + p + 1 + $urandom_range(0, 3);
      if ($urandom_range(5) == 0) k = (k > 3) ? k - $urandom_range(1, 3) : 0;
      s = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
      run_curve(p, n, k, s, $urandom_range(2, 5), $urandom_range(7) == 0);
      c++;
    end

    drain();
    $display("Sent %0d items over %0d curve setups; %0d points checked, %0d fallbacks.",
             items_seen, c + 2, points_seen, fallbacks_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
